### hdl/fsig_pkg.sv
// Package with types, constants and signature tables for the file signature matcher.
`default_nettype none

package fsig_pkg;

   localparam int NUM_SIGS      = 21;
   localparam int SIG_MAX       = 16;
   localparam int HEADER_WINDOW = 32;
   localparam int POS_W         = 6;
   localparam int POS_MAX       = (1 << POS_W) - 1;
   localparam int CODE_W        = 5;
   localparam int SIG_IDX_W     = $clog2(SIG_MAX);

   typedef logic [NUM_SIGS-1:0] mask_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CODE_W-1:0]   code_type;

   // One input transfer
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } item_type;

   // One result transfer
   typedef struct packed {
      logic     match_found;
      code_type format_code;
   } result_type;

   localparam mask_type ALL_SIGS = '1;

   // Expected byte per signature and position (wildcard slots hold zero)
   localparam logic [7:0] SIG_BYTE [NUM_SIGS][SIG_MAX] = '{
      '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h41, 8'h56, 8'h49, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},   // AVI
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // GIF87a
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // GIF89a
      '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // ICON
      '{8'h43, 8'h44, 8'h30, 8'h30, 8'h31, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // ISO9660
      '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h00, 8'h45, 8'h78,
        8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // JPEG Exif
      '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h10, 8'h4A, 8'h46,
        8'h49, 8'h46, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},   // JPEG JFIF
      '{8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // JPEG raw DB
      '{8'hFF, 8'hD8, 8'hFF, 8'hEE, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // JPEG raw EE
      '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // MP3 ID3v2
      '{8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // MP3 plain
      '{8'hA1, 8'hB2, 8'hC3, 8'hD4, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // PCAP big
      '{8'hD4, 8'hC3, 8'hB2, 8'hA1, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // PCAP little
      '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // PDF
      '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // PNG
      '{8'h38, 8'h42, 8'h50, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // PSD
      '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // RAR 1.5
      '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h01, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // RAR 5
      '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h57, 8'h41, 8'h56, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},   // WAV
      '{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // XML
      '{8'h62, 8'h6F, 8'h6F, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h6D, 8'h61, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00}    // file alias
   };

   // Bit j set where position j is inside the signature and not a wildcard
   localparam logic [SIG_MAX-1:0] SIG_CARE [NUM_SIGS] = '{
      16'h0F0F, 16'h003F, 16'h003F, 16'h000F, 16'h001F, 16'h0FCF, 16'h0FFF,
      16'h000F, 16'h000F, 16'h0007, 16'h0003, 16'h000F, 16'h000F, 16'h001F,
      16'h00FF, 16'h000F, 16'h007F, 16'h00FF, 16'h0F0F, 16'h003F, 16'hFFFF
   };

endpackage

`default_nettype wire

### hdl/fsig_match.sv
// Per-byte signature compare, candidate mask update and priority encode.
`default_nettype none

module fsig_match (
   input  wire fsig_pkg::item_type   item,
   input  wire fsig_pkg::pos_type    pos,
   input  wire fsig_pkg::mask_type   mask,
   output fsig_pkg::mask_type        next_mask,
   output fsig_pkg::result_type      result
);

   logic                                   in_sigs;
   logic [fsig_pkg::SIG_IDX_W-1:0]         pidx;
   logic [fsig_pkg::SIG_MAX-1:0]           later;
   fsig_pkg::mask_type                     reject;
   fsig_pkg::mask_type                     final_mask;

   // Position decode: byte slot and the positions not yet seen
   always_comb begin
      in_sigs = (pos < fsig_pkg::POS_W'(fsig_pkg::SIG_MAX)) &&
                (pos < fsig_pkg::POS_W'(fsig_pkg::HEADER_WINDOW));
      pidx    = pos[fsig_pkg::SIG_IDX_W-1:0];
      for (int j = 0; j < fsig_pkg::SIG_MAX; j++) begin
         later[j] = (fsig_pkg::POS_W'(j) > pos) &&
                    (j < fsig_pkg::HEADER_WINDOW);
      end
   end

   // All signatures compared in parallel; on the last byte the unseen
   // non-wildcard positions count as missing
   always_comb begin
      for (int k = 0; k < fsig_pkg::NUM_SIGS; k++) begin
         reject[k] = (in_sigs && fsig_pkg::SIG_CARE[k][pidx] &&
                      (!item.byte_present || item.data_byte != fsig_pkg::SIG_BYTE[k][pidx]))
                     || (item.last_byte && |(fsig_pkg::SIG_CARE[k] & later));
      end
      next_mask  = mask & ~reject;
      final_mask = next_mask;
   end

   // Lowest surviving signature wins
   always_comb begin
      result.match_found = |final_mask;
      result.format_code = '0;
      for (int k = fsig_pkg::NUM_SIGS - 1; k >= 0; k--) begin
         if (final_mask[k]) begin
            result.format_code = fsig_pkg::CODE_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

### hdl/file_signature_matcher_core.sv
// Top level of the file signature matcher: input register, state and result register.
//
// Usage: feed the leading bytes of a file on the req_ channel, one byte per
// transfer, in file order. req_byte_present low marks a position past the end
// of the file; req_last_byte high closes the header window. Each window
// produces exactly one rsp_ transfer carrying rsp_match_found and
// rsp_format_code (lowest matching signature, 0 when none matched).
// Throughput: one byte per cycle while no last byte waits on a stalled result, set by
// the single compare stage that checks all 21 signatures at once against the byte
// position counter. A last byte passes through the input register, then the result
// register, before it appears on rsp_.
// Stall: a stalled result holds on rsp_; non-last bytes keep flowing, and
// the next last byte waits in the input register, raising req_stall.
// Reset (synchronous, active high) empties both registers, clears the byte
// position and marks every signature as possible; req_stall is high during
// reset.
`default_nettype none

module file_signature_matcher_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [7:0]                    req_data_byte,
   input  wire                          req_byte_present,
   input  wire                          req_last_byte,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_match_found,
   output logic [fsig_pkg::CODE_W-1:0]  rsp_format_code
);

   logic                  s1_valid_ff, s1_valid_in;
   fsig_pkg::item_type    item_ff, item_in;
   fsig_pkg::pos_type     pos_ff, pos_in;
   fsig_pkg::mask_type    mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fsig_pkg::result_type  rsp_ff, rsp_in;

   fsig_pkg::mask_type    next_mask;
   fsig_pkg::result_type  result;
   logic                  req_accept;
   logic                  s1_advance;

   fsig_match u_match (
      .item      (item_ff),
      .pos       (pos_ff),
      .mask      (mask_ff),
      .next_mask (next_mask),
      .result    (result)
   );

   // Handshake: only a last byte can be held back by a stalled result
   always_comb begin
      s1_advance = s1_valid_ff &&
                   (!item_ff.last_byte || !rsp_valid_ff || !rsp_stall);
      req_stall  = reset || (s1_valid_ff && !s1_advance);
      req_accept = req_valid && !req_stall;
   end

   // Input register
   always_comb begin
      item_in     = item_ff;
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         item_in.data_byte    = req_data_byte;
         item_in.byte_present = req_byte_present;
         item_in.last_byte    = req_last_byte;
         s1_valid_in          = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Byte position and candidate mask
   always_comb begin
      pos_in  = pos_ff;
      mask_in = mask_ff;
      if (s1_advance) begin
         if (item_ff.last_byte) begin
            pos_in  = '0;
            mask_in = fsig_pkg::ALL_SIGS;
         end else begin
            mask_in = next_mask;
            if (pos_ff != fsig_pkg::POS_W'(fsig_pkg::POS_MAX)) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && item_ff.last_byte) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         mask_ff      <= fsig_pkg::ALL_SIGS;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         mask_ff      <= mask_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_ff.match_found;
   assign rsp_format_code = rsp_ff.format_code;

endmodule

`default_nettype wire

### hdl/fsig_checker.sv
// Port-level checker for the file signature matcher, bound to the top level.
`default_nettype none

module fsig_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          req_last_byte,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire                          rsp_match_found,
   input wire [fsig_pkg::CODE_W-1:0]   rsp_format_code
);

   logic last_xfer;

   assign last_xfer = req_valid && !req_stall && req_last_byte;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_found) &&
                                 $stable(rsp_format_code))
      else $error("stalled result changed");

   // No match reports code zero; codes stay within the signature list
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_found ||
                     rsp_format_code == fsig_pkg::CODE_W'(0)) &&
                    rsp_format_code < fsig_pkg::CODE_W'(fsig_pkg::NUM_SIGS))
      else $error("bad format code");

   // A new result follows a last-byte transfer through the input and result registers
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_xfer, 2))
      else $error("result without last byte");

   // Reset empties the result register and blocks input
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_stall: assert property (@(posedge clock)
      reset |-> req_stall)
      else $error("input accepted during reset");

endmodule

bind file_signature_matcher_core fsig_checker u_fsig_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last_byte   (req_last_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_match_found (rsp_match_found),
   .rsp_format_code (rsp_format_code)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the file signature matcher core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsig_pkg::*;

   localparam int WILD = -1;

   // Signature lengths and bytes, kept apart from the design tables
   localparam int SIG_LEN [NUM_SIGS] = '{
      12, 6, 6, 4, 5, 12, 12, 4, 4, 3, 2, 4, 4, 5, 8, 4, 7, 8, 12, 6, 16
   };

   localparam int SIG_PAT [NUM_SIGS][SIG_MAX] = '{
      '{'h52, 'h49, 'h46, 'h46, WILD, WILD, WILD, WILD,
        'h41, 'h56, 'h49, 'h20, 0, 0, 0, 0},
      '{'h47, 'h49, 'h46, 'h38, 'h37, 'h61, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h47, 'h49, 'h46, 'h38, 'h39, 'h61, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h00, 'h01, 'h00, 'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h43, 'h44, 'h30, 'h30, 'h31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'hFF, 'hD8, 'hFF, 'hE1, WILD, WILD, 'h45, 'h78,
        'h69, 'h66, 'h00, 'h00, 0, 0, 0, 0},
      '{'hFF, 'hD8, 'hFF, 'hE0, 'h00, 'h10, 'h4A, 'h46,
        'h49, 'h46, 'h00, 'h01, 0, 0, 0, 0},
      '{'hFF, 'hD8, 'hFF, 'hDB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'hFF, 'hD8, 'hFF, 'hEE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h49, 'h44, 'h33, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'hFF, 'hFB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'hA1, 'hB2, 'hC3, 'hD4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'hD4, 'hC3, 'hB2, 'hA1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h25, 'h50, 'h44, 'h46, 'h2D, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h89, 'h50, 'h4E, 'h47, 'h0D, 'h0A, 'h1A, 'h0A, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h38, 'h42, 'h50, 'h53, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h52, 'h61, 'h72, 'h21, 'h1A, 'h07, 'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h52, 'h61, 'h72, 'h21, 'h1A, 'h07, 'h01, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h52, 'h49, 'h46, 'h46, WILD, WILD, WILD, WILD,
        'h57, 'h41, 'h56, 'h45, 0, 0, 0, 0},
      '{'h3C, 'h3F, 'h78, 'h6D, 'h6C, 'h20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{'h62, 'h6F, 'h6F, 'h6B, 'h00, 'h00, 'h00, 'h00,
        'h6D, 'h61, 'h72, 'h6B, 'h00, 'h00, 'h00, 'h00}
   };

   localparam int PNG_SIG = 14;
   localparam int AVI_SIG = 0;
   localparam int ID3_SIG = 9;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_byte_present = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_match_found;
   code_type   rsp_format_code;

   // Predictor state
   pos_type    track_pos = '0;
   mask_type   track_mask = ALL_SIGS;
   result_type expected_verdicts [$];

   bit idle_on = 1'b1;
   int errors = 0;
   int byte_count = 0;
   int window_count = 0;
   int match_count = 0;

   file_signature_matcher_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_found  (rsp_match_found),
      .rsp_format_code  (rsp_format_code)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("%0t: run timed out", $time);
      $display("FAILURE");
      $finish;
   end

   // True when signature k cannot hold this byte (or a missing one) at pos
   function automatic bit sig_rejects(int k, int pos, logic present, logic [7:0] b);
      if (pos >= SIG_LEN[k]) return 1'b0;
      if (SIG_PAT[k][pos] == WILD) return 1'b0;
      if (!present) return 1'b1;
      return SIG_PAT[k][pos] != int'(b);
   endfunction

   // Advance the predicted state by one accepted byte; queue a verdict on last
   function automatic void track_byte(logic [7:0] b, logic present, logic last);
      int pos;
      result_type verdict;
      pos = int'(track_pos);
      if (pos < HEADER_WINDOW) begin
         for (int k = 0; k < NUM_SIGS; k++)
            if (sig_rejects(k, pos, present, b)) track_mask[k] = 1'b0;
      end
      if (!last) begin
         if (pos < POS_MAX) track_pos = pos_type'(pos + 1);
         return;
      end
      // positions the window never reached count as missing
      for (int k = 0; k < NUM_SIGS; k++)
         for (int j = pos + 1; j < SIG_LEN[k] && j < HEADER_WINDOW; j++)
            if (sig_rejects(k, j, 1'b0, 8'h00)) track_mask[k] = 1'b0;
      verdict = '0;
      for (int k = NUM_SIGS - 1; k >= 0; k--) begin
         if (track_mask[k]) begin
            verdict.match_found = 1'b1;
            verdict.format_code = code_type'(k);
         end
      end
      expected_verdicts.push_back(verdict);
      window_count++;
      track_pos = '0;
      track_mask = ALL_SIGS;
   endfunction

   // Send one header byte; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] d, input logic p, input logic l);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_byte_present <= p;
      req_last_byte    <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_byte(d, p, l);
      byte_count++;
      @(negedge clock);
   endtask

   // One window built from signature k: optional tail, truncation or a bad byte
   task automatic send_signature(input int k, input int extra, input bit truncate,
                                 input bit corrupt);
      int len;
      int n;
      int bad;
      logic [7:0] d;
      logic p;
      len = SIG_LEN[k];
      n = truncate ? $urandom_range(1, len - 1) : len + extra;
      bad = corrupt ? $urandom_range(0, n - 1) : -1;
      for (int j = 0; j < n; j++) begin
         p = 1'b1;
         d = 8'($urandom);
         if (j < len && SIG_PAT[k][j] != WILD) d = 8'(SIG_PAT[k][j]);
         else if ($urandom_range(0, 3) == 0) p = 1'b0;
         if (j == bad) begin
            if ($urandom_range(0, 2) == 0) p = 1'b0;
            else d = d ^ (8'd1 << $urandom_range(0, 7));
         end
         send_byte(d, p, j == n - 1);
      end
   endtask

   // Random bytes with no signature behind them
   task automatic send_noise(input int n);
      for (int j = 0; j < n; j++)
         send_byte(8'($urandom), $urandom_range(0, 4) != 0, j == n - 1);
   endtask

   // Mixed window: mostly well formed, some broken, some noise, rare long ones
   task automatic send_random_window();
      int r;
      int k;
      r = $urandom_range(0, 29);
      k = $urandom_range(0, NUM_SIGS - 1);
      if (r == 0) send_signature(k, $urandom_range(50, 75), 1'b0, 1'b0);
      else if (r < 6) send_noise($urandom_range(1, 20));
      else if (r < 9) send_signature(k, 0, 1'b1, 1'b0);
      else if (r < 15) send_signature(k, $urandom_range(0, 4), 1'b0, 1'b1);
      else send_signature(k, $urandom_range(0, 4), 1'b0, 1'b0);
   endtask

   // Single item that is both first and last, missing, all ones data
   task automatic test_lone_last_byte();
      send_byte(8'hFF, 1'b0, 1'b1);
   endtask

   // Complete PNG signature ending the window on its final byte
   task automatic test_exact_png();
      for (int j = 0; j < SIG_LEN[PNG_SIG]; j++)
         send_byte(8'(SIG_PAT[PNG_SIG][j]), 1'b1, j == SIG_LEN[PNG_SIG] - 1);
   endtask

   // AVI with its wildcard slots missing; wildcards accept a missing byte
   task automatic test_missing_wildcards();
      for (int j = 0; j < SIG_LEN[AVI_SIG]; j++) begin
         if (SIG_PAT[AVI_SIG][j] == WILD) send_byte(8'h00, 1'b0, 1'b0);
         else send_byte(8'(SIG_PAT[AVI_SIG][j]), 1'b1, j == SIG_LEN[AVI_SIG] - 1);
      end
   endtask

   // Window closed after three bytes: longer signatures see missing bytes
   task automatic test_early_window_end();
      for (int j = 0; j < SIG_LEN[ID3_SIG]; j++)
         send_byte(8'(SIG_PAT[ID3_SIG][j]), 1'b1, j == SIG_LEN[ID3_SIG] - 1);
   endtask

   task automatic test_random_headers();
      idle_on = 1'b1;
      while (byte_count < 900) send_random_window();
   endtask

   // Last stretch at full rate on both sides
   task automatic test_back_to_back();
      idle_on = 1'b0;
      while (byte_count < 1050) send_random_window();
   endtask

   // Receiver stalls in random bursts
   always begin
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 9)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest queued verdict
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result with none expected, match_found %0b format_code %0d",
                     $time, rsp_match_found, rsp_format_code);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_match_found !== want.match_found) begin
               $display("%0t: match_found expected %0b, got %0b",
                        $time, want.match_found, rsp_match_found);
               errors++;
            end
            if (rsp_format_code !== want.format_code) begin
               $display("%0t: format_code expected %0d, got %0d",
                        $time, want.format_code, rsp_format_code);
               errors++;
            end
            if (want.match_found) match_count++;
         end
      end
   end

   initial begin
      int waited;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_lone_last_byte();
      test_exact_png();
      test_missing_wildcards();
      test_early_window_end();
      test_random_headers();
      test_back_to_back();

      req_valid <= 1'b0;
      waited = 0;
      while (expected_verdicts.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_verdicts.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_verdicts.size());
         errors++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d header bytes in %0d windows; %0d windows matched a signature.",
               byte_count, window_count, match_count);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
hdl/fsig_pkg.sv
hdl/fsig_match.sv
hdl/file_signature_matcher_core.sv
hdl/fsig_checker.sv
verif/tb.sv
